// File: src/rois_pkg.sv
// rois_pkg: shared widths, register indexes and controller/datapath types
// for the ROI image scaler. No dependencies.
`default_nettype none

package rois_pkg;

	localparam int COORD_W = 10;
	localparam int DIM_W   = 11;
	localparam int PIX_W   = 8;
	localparam int KIND_W  = 2;
	localparam int IDX_W   = 3;
	localparam int FRAC_W  = 16;
	localparam int P_W     = COORD_W + DIM_W;
	localparam int NUM_W   = P_W + FRAC_W;
	localparam int CNT_W   = $clog2(NUM_W);
	localparam int POS_W   = NUM_W + 1;
	localparam int SC_W    = POS_W - FRAC_W + 2;
	localparam int WGT_W   = 18;
	localparam int ACC_W   = 48;
	localparam int DIV_STEPS = 3;

	localparam int DEF_MAX_W = 1024;
	localparam int DEF_MAX_H = 1024;
	localparam int DEF_OUT_W = 800;
	localparam int DEF_OUT_H = 440;

	localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [IDX_W-1:0] REG_ROI_X        = 3'd2;
	localparam logic [IDX_W-1:0] REG_ROI_Y        = 3'd3;
	localparam logic [IDX_W-1:0] REG_ROI_WIDTH    = 3'd4;
	localparam logic [IDX_W-1:0] REG_ROI_HEIGHT   = 3'd5;
	localparam logic [IDX_W-1:0] REG_INTERP_KIND  = 3'd6;

	localparam logic [KIND_W-1:0] KIND_NEAREST  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BILINEAR = 2'd1;

	// position divider phases
	localparam logic [1:0] DSTEP_EST = 2'd0;
	localparam logic [1:0] DSTEP_REM = 2'd1;
	localparam logic [1:0] DSTEP_FIX = 2'd2;

	typedef struct packed {
		logic       load;
		logic       render;
		logic       mul;
		logic       div_step;
		logic [1:0] dstep;
		logic       pos;
		logic       coord;
		logic       rowb;
		logic       wfeed;
		logic [2:0] widx;
		logic       tap;
		logic [1:0] tn;
		logic [1:0] tm;
		logic       result;
	} rois_cmd_t;

	typedef struct packed {
		logic       bicubic;
		logic [1:0] tap_last;
	} rois_sts_t;

endpackage

`default_nettype wire

// File: src/rois_ram.sv
// rois_ram: generic one-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rois_ram #(
	parameter int DW    = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DW-1:0]            wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [DW-1:0]            rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: src/rois_ctrl.sv
// rois_ctrl: sequencing state machine for the ROI image scaler.
// Depends on rois_pkg for command/status types.
`default_nettype none

module rois_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                mode,
	input  wire logic                out_stall,
	input  wire rois_pkg::rois_sts_t sts,
	output logic                     in_stall,
	output logic                     out_valid,
	output rois_pkg::rois_cmd_t      cmd
);
	import rois_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MUL   = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_POS   = 4'd3;
	localparam logic [3:0] S_COORD = 4'd4;
	localparam logic [3:0] S_ROWB  = 4'd5;
	localparam logic [3:0] S_WGT   = 4'd6;
	localparam logic [3:0] S_TAPS  = 4'd7;
	localparam logic [3:0] S_DRAIN = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	logic [3:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       n_q;
	logic [1:0]       m_q;
	logic             out_valid_q;
	logic             accept;
	logic             out_free;

	assign accept    = in_valid && (state_q == S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = accept && !mode;
		cmd.render   = accept && mode;
		cmd.mul      = (state_q == S_MUL);
		cmd.div_step = (state_q == S_DIV);
		cmd.dstep    = cnt_q[1:0];
		cmd.pos      = (state_q == S_POS);
		cmd.coord    = (state_q == S_COORD);
		cmd.rowb     = (state_q == S_ROWB);
		cmd.wfeed    = (state_q == S_WGT) && (cnt_q < CNT_W'(8));
		cmd.widx     = cnt_q[2:0];
		cmd.tap      = (state_q == S_TAPS);
		cmd.tn       = n_q;
		cmd.tm       = m_q;
		cmd.result   = (state_q == S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			n_q     <= '0;
			m_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.render) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= S_POS;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_POS: begin
					state_q <= S_COORD;
				end
				S_COORD: begin
					state_q <= S_ROWB;
				end
				S_ROWB: begin
					cnt_q   <= '0;
					n_q     <= '0;
					m_q     <= '0;
					state_q <= sts.bicubic ? S_WGT : S_TAPS;
				end
				S_WGT: begin
					if (cnt_q == CNT_W'(9)) begin
						state_q <= S_TAPS;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_TAPS: begin
					if (n_q == sts.tap_last) begin
						n_q <= '0;
						if (m_q == sts.tap_last) begin
							cnt_q   <= '0;
							state_q <= S_DRAIN;
						end else begin
							m_q <= m_q + 1'b1;
						end
					end else begin
						n_q <= n_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (cnt_q == CNT_W'(1)) begin
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q == CNT_W'(DIV_STEPS - 1)) |=> (state_q == S_POS))
		else $error("divider did not finish after DIV_STEPS steps");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result raised outside DONE");

	a_render_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.render |=> (state_q == S_MUL))
		else $error("render beat did not start sequence");

	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TAPS) |-> (n_q <= sts.tap_last && m_q <= sts.tap_last))
		else $error("tap index past window");

endmodule

`default_nettype wire

// File: src/rois_dp.sv
// rois_dp: ROI scaler datapath: config registers, position divider, tap
// address/weight generation, Keys weight pipe, MAC and frame store.
// Depends on rois_pkg and rois_ram.
`default_nettype none

module rois_dp #(
	parameter int MAX_W = rois_pkg::DEF_MAX_W,
	parameter int MAX_H = rois_pkg::DEF_MAX_H,
	parameter int OUT_W = rois_pkg::DEF_OUT_W,
	parameter int OUT_H = rois_pkg::DEF_OUT_H
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rois_pkg::rois_cmd_t           cmd,
	output rois_pkg::rois_sts_t                sts,
	input  wire logic [rois_pkg::COORD_W-1:0]  col,
	input  wire logic [rois_pkg::COORD_W-1:0]  row,
	input  wire logic [rois_pkg::PIX_W-1:0]    pixel_in,
	input  wire logic                          cfg_we,
	input  wire logic [rois_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [rois_pkg::DIM_W-1:0]    cfg_data,
	output logic      [rois_pkg::PIX_W-1:0]    pixel_out,
	output logic      [rois_pkg::COORD_W-1:0]  out_col,
	output logic      [rois_pkg::COORD_W-1:0]  out_row
);
	import rois_pkg::*;

	localparam int AW  = $clog2(MAX_W * MAX_H);
	localparam int XW  = $clog2(MAX_W);
	localparam int YW  = $clog2(MAX_H);
	localparam int EXW = $clog2(MAX_W + 1);
	localparam int EYW = $clog2(MAX_H + 1);
	localparam int RXW = $clog2(OUT_W + 1);
	localparam int RYW = $clog2(OUT_H + 1);
	localparam logic signed [ACC_W-1:0] ACC_MAX = 48'sd1095216660480;

	// reciprocals floor(2^NUM_W / OUT_*) for the position divide
	localparam longint RECX_L = (longint'(1) << NUM_W) / OUT_W;
	localparam longint RECY_L = (longint'(1) << NUM_W) / OUT_H;
	localparam int     RCXW   = $clog2(RECX_L + 1);
	localparam int     RCYW   = $clog2(RECY_L + 1);
	localparam logic [RCXW-1:0] RECX = RCXW'(RECX_L);
	localparam logic [RCYW-1:0] RECY = RCYW'(RECY_L);
	localparam logic [RXW-1:0]  DIVX = RXW'(OUT_W);
	localparam logic [RYW-1:0]  DIVY = RYW'(OUT_H);

	// config
	logic [DIM_W-1:0]   image_width_q, image_height_q, roi_width_q, roi_height_q;
	logic [COORD_W-1:0] roi_x_q, roi_y_q;
	logic [KIND_W-1:0]  interp_kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= 11'd1024;
			image_height_q <= 11'd1024;
			roi_x_q        <= '0;
			roi_y_q        <= '0;
			roi_width_q    <= 11'd1024;
			roi_height_q   <= 11'd1024;
			interp_kind_q  <= KIND_NEAREST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				REG_ROI_X:        roi_x_q        <= cfg_data[COORD_W-1:0];
				REG_ROI_Y:        roi_y_q        <= cfg_data[COORD_W-1:0];
				REG_ROI_WIDTH:    roi_width_q    <= cfg_data;
				REG_ROI_HEIGHT:   roi_height_q   <= cfg_data;
				REG_INTERP_KIND:  interp_kind_q  <= cfg_data[KIND_W-1:0];
				default: ;
			endcase
		end
	end

	logic is_bicubic;
	assign is_bicubic   = interp_kind_q[1];
	assign sts.bicubic  = is_bicubic;
	assign sts.tap_last = is_bicubic ? 2'd3 :
		((interp_kind_q == KIND_BILINEAR) ? 2'd1 : 2'd0);

	// frame store
	logic          ld_ok;
	logic [AW-1:0] waddr, raddr;
	logic [PIX_W-1:0] rdata;

	assign ld_ok = (32'(col) < MAX_W) && (32'(row) < MAX_H);
	assign waddr = AW'(32'(row) * MAX_W + 32'(col));

	rois_ram #(.DW(PIX_W), .DEPTH(MAX_W * MAX_H)) u_frame (
		.clk   (clk),
		.we    (cmd.load && ld_ok),
		.waddr (waddr),
		.wdata (pixel_in),
		.raddr (raddr),
		.rdata (rdata)
	);

	// position: col*roi_width*2^16 / OUT_W; reciprocal estimate is low by at
	// most one, fixed by one compare and increment
	logic [COORD_W-1:0]  col_q, row_q;
	logic [P_W-1:0]      numx_q, numy_q;
	logic [NUM_W-1:0]    qx_q, qy_q;
	logic [RXW:0]        remx_q;
	logic [RYW:0]        remy_q;
	logic [P_W+RCXW-1:0] estx;
	logic [P_W+RCYW-1:0] esty;
	logic [NUM_W-1:0]    backx, backy, difx, dify;
	logic                gex, gey;

	assign estx  = (P_W+RCXW)'(numx_q) * (P_W+RCXW)'(RECX);
	assign esty  = (P_W+RCYW)'(numy_q) * (P_W+RCYW)'(RECY);
	assign backx = qx_q * NUM_W'(DIVX);
	assign backy = qy_q * NUM_W'(DIVY);
	assign difx  = {numx_q, FRAC_W'(0)} - backx;
	assign dify  = {numy_q, FRAC_W'(0)} - backy;
	assign gex   = (32'(remx_q) >= OUT_W);
	assign gey   = (32'(remy_q) >= OUT_H);

	always_ff @(posedge clk) begin
		if (cmd.render) begin
			col_q <= col;
			row_q <= row;
		end
		if (cmd.mul) begin
			numx_q <= P_W'(col_q) * P_W'(roi_width_q);
			numy_q <= P_W'(row_q) * P_W'(roi_height_q);
		end else if (cmd.div_step) begin
			unique case (cmd.dstep)
				DSTEP_EST: begin
					qx_q <= NUM_W'(estx[P_W+RCXW-1:P_W]);
					qy_q <= NUM_W'(esty[P_W+RCYW-1:P_W]);
				end
				DSTEP_REM: begin
					remx_q <= difx[RXW:0];
					remy_q <= dify[RYW:0];
				end
				DSTEP_FIX: begin
					if (gex) begin
						qx_q <= qx_q + NUM_W'(1);
					end
					if (gey) begin
						qy_q <= qy_q + NUM_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	logic [POS_W-1:0] posx_q, posy_q;
	logic [EXW-1:0]   effw_q;
	logic [EYW-1:0]   effh_q;

	always_ff @(posedge clk) begin
		if (cmd.pos) begin
			posx_q <= POS_W'({roi_x_q, FRAC_W'(0)}) + POS_W'(qx_q);
			posy_q <= POS_W'({roi_y_q, FRAC_W'(0)}) + POS_W'(qy_q);
			effw_q <= (image_width_q == '0) ? EXW'(1) :
				((32'(image_width_q) > MAX_W) ? EXW'(MAX_W) : EXW'(image_width_q));
			effh_q <= (image_height_q == '0) ? EYW'(1) :
				((32'(image_height_q) > MAX_H) ? EYW'(MAX_H) : EYW'(image_height_q));
		end
	end

	// tap coordinates
	function automatic logic signed [SC_W-1:0] axis_base(
		input logic [POS_W-1:0]  p,
		input logic [KIND_W-1:0] kind
	);
		logic [POS_W:0] pr;
		pr = {1'b0, p} + (POS_W + 1)'(32768);
		if (kind == KIND_NEAREST) begin
			return $signed(SC_W'(pr[POS_W:FRAC_W]));
		end else if (kind == KIND_BILINEAR) begin
			return $signed(SC_W'(p[POS_W-1:FRAC_W]));
		end
		return $signed(SC_W'(p[POS_W-1:FRAC_W])) - SC_W'(1);
	endfunction

	function automatic logic signed [SC_W-1:0] clamp_c(
		input logic signed [SC_W-1:0] v,
		input logic [12:0]            n
	);
		logic signed [SC_W-1:0] ns;
		ns = $signed(SC_W'(n));
		if (v < 0) begin
			return '0;
		end else if (v >= ns) begin
			return ns - SC_W'(1);
		end
		return v;
	endfunction

	logic signed [SC_W-1:0] basex, basey;
	logic [XW-1:0]          cx_q [4];
	logic [YW-1:0]          cy_q [4];
	logic [AW-1:0]          rowbase_q [4];

	assign basex = axis_base(posx_q, interp_kind_q);
	assign basey = axis_base(posy_q, interp_kind_q);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			if (cmd.coord) begin
				cx_q[i] <= XW'(clamp_c(basex + SC_W'(i), 13'(effw_q)));
				cy_q[i] <= YW'(clamp_c(basey + SC_W'(i), 13'(effh_q)));
			end
			if (cmd.rowb) begin
				rowbase_q[i] <= AW'(32'(cy_q[i]) * MAX_W);
			end
		end
	end

	// Keys weight pipe
	logic [FRAC_W-1:0]      fx, fy, fr;
	logic [WGT_W-1:0]       ku_in;
	logic [WGT_W-1:0]       ku_s1, ku_s2;
	logic [2*WGT_W-1:0]     ku2_s1, ku2_s2;
	logic [3*WGT_W-1:0]     ku3_s2;
	logic [2:0]             kidx_s1, kidx_s2;
	logic                   kv_s1, kv_s2;
	logic signed [57:0]     ku3s, ku2s, kus, kt;
	logic signed [WGT_W-1:0] kw;

	assign fx = posx_q[FRAC_W-1:0];
	assign fy = posy_q[FRAC_W-1:0];
	assign fr = cmd.widx[2] ? fy : fx;

	always_comb begin
		unique case (cmd.widx[1:0])
			2'd0:    ku_in = {2'b00, fr} + 18'd65536;
			2'd1:    ku_in = {2'b00, fr};
			2'd2:    ku_in = 18'd65536 - {2'b00, fr};
			default: ku_in = 18'd131072 - {2'b00, fr};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kv_s1 <= 1'b0;
			kv_s2 <= 1'b0;
		end else begin
			kv_s1 <= cmd.wfeed;
			kv_s2 <= kv_s1;
		end
	end

	always_ff @(posedge clk) begin
		ku_s1   <= ku_in;
		ku2_s1  <= ku_in * ku_in;
		kidx_s1 <= cmd.widx;
		ku_s2   <= ku_s1;
		ku2_s2  <= ku2_s1;
		ku3_s2  <= ku2_s1 * ku_s1;
		kidx_s2 <= kidx_s1;
	end

	always_comb begin
		ku3s = $signed({4'b0, ku3_s2});
		ku2s = $signed({22'b0, ku2_s2});
		kus  = $signed({40'b0, ku_s2});
		kt   = '0;
		kw   = '0;
		if (ku_s2 <= 18'd65536) begin
			kt = 3 * ku3s - ((5 * ku2s) <<< 16) + (58'sd1 <<< 49) + (58'sd1 <<< 32);
			kw = WGT_W'(kt >>> 33);
		end else if (ku_s2 < 18'd131072) begin
			kt = ku3s - ((5 * ku2s) <<< 16) + (kus <<< 35) - (58'sd1 <<< 50)
				+ (58'sd1 <<< 32);
			kw = -WGT_W'(kt >>> 33);
		end
	end

	// weights
	logic signed [WGT_W-1:0] wx_q [4];
	logic signed [WGT_W-1:0] wy_q [4];
	logic signed [WGT_W-1:0] fxs, fys;

	assign fxs = $signed({2'b00, fx});
	assign fys = $signed({2'b00, fy});

	always_ff @(posedge clk) begin
		if (cmd.coord) begin
			for (int i = 0; i < 4; i++) begin
				wx_q[i] <= '0;
				wy_q[i] <= '0;
			end
			if (interp_kind_q == KIND_NEAREST) begin
				wx_q[0] <= 18'sd65536;
				wy_q[0] <= 18'sd65536;
			end else if (interp_kind_q == KIND_BILINEAR) begin
				wx_q[0] <= 18'sd65536 - fxs;
				wx_q[1] <= fxs;
				wy_q[0] <= 18'sd65536 - fys;
				wy_q[1] <= fys;
			end
		end else if (kv_s2) begin
			if (kidx_s2[2]) begin
				wy_q[kidx_s2[1:0]] <= kw;
			end else begin
				wx_q[kidx_s2[1:0]] <= kw;
			end
		end
	end

	// tap MAC
	logic signed [2*WGT_W-1:0]      wprod_s1;
	logic signed [2*WGT_W+PIX_W:0]  prod_s2;
	logic                           tap_s1, tap_s2;
	logic signed [ACC_W-1:0]        acc_q, acc_rnd;
	logic [PIX_W-1:0]               res;

	assign raddr = rowbase_q[cmd.tm] + AW'(cx_q[cmd.tn]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s1 <= 1'b0;
			tap_s2 <= 1'b0;
		end else begin
			tap_s1 <= cmd.tap;
			tap_s2 <= tap_s1;
		end
	end

	always_ff @(posedge clk) begin
		wprod_s1 <= wx_q[cmd.tn] * wy_q[cmd.tm];
		prod_s2  <= $signed({1'b0, rdata}) * wprod_s1;
		if (cmd.coord) begin
			acc_q <= '0;
		end else if (tap_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign acc_rnd = acc_q + (48'sd1 <<< 31);

	always_comb begin
		if (is_bicubic) begin
			if (acc_q < 0) begin
				res = '0;
			end else if (acc_q > ACC_MAX) begin
				res = 8'd255;
			end else begin
				res = acc_q[39:32];
			end
		end else begin
			res = acc_rnd[39:32];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result) begin
			pixel_out <= res;
			out_col   <= col_q;
			out_row   <= row_q;
		end
	end

	a_no_wgt_clash: assert property (@(posedge clk) disable iff (!arst_n)
		kv_s2 |-> !cmd.coord && !cmd.tap)
		else $error("weight write overlaps tap phase");

	a_tap_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		tap_s2 |-> $past(cmd.tap, 2))
		else $error("MAC pipe out of step");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !tap_s1 && !tap_s2 && !kv_s1)
		else $error("load during render");

endmodule

`default_nettype wire

// File: src/roi_image_scaler_core.sv
// roi_image_scaler_core: top level of the ROI grayscale image scaler.
// Depends on rois_pkg, rois_ctrl, rois_dp (which holds rois_ram).
//
// Use: an input beat with mode=0 writes pixel_in at (col,row) of the frame
// store (dropped if outside MAX_W x MAX_H) and gives no result. A beat with
// mode=1 renders output pixel (col,row): the source position roi +
// col*roi_width/OUT_W comes from a reciprocal multiply with one correction
// step, then 1, 4 or 16 taps are read one a cycle from the frame memory's
// single read port and accumulated. Bicubic also computes the Keys weights
// before its taps. One render in flight.
// in_stall is high from a render accept until its result sits in the output
// register; the next beat is taken while that result waits. A stalled output
// holds its beat; the block then waits before finishing the next render.
// Config: cfg_ready is always high; write only while idle. Index 0..6 selects
// image_width, image_height, roi_x, roi_y, roi_width, roi_height, interp_kind.
// Reset (arst_n low) clears control and config to defaults; the frame store
// is not cleared and each pixel must be loaded before it is read.
`default_nettype none

module roi_image_scaler_core #(
	parameter int MAX_W = rois_pkg::DEF_MAX_W,
	parameter int MAX_H = rois_pkg::DEF_MAX_H,
	parameter int OUT_W = rois_pkg::DEF_OUT_W,
	parameter int OUT_H = rois_pkg::DEF_OUT_H
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         mode,
	input  wire logic [rois_pkg::COORD_W-1:0] col,
	input  wire logic [rois_pkg::COORD_W-1:0] row,
	input  wire logic [rois_pkg::PIX_W-1:0]   pixel_in,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [rois_pkg::PIX_W-1:0]   pixel_out,
	output logic      [rois_pkg::COORD_W-1:0] out_col,
	output logic      [rois_pkg::COORD_W-1:0] out_row,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [rois_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [rois_pkg::DIM_W-1:0]   cfg_data
);
	import rois_pkg::*;

	rois_cmd_t cmd;
	rois_sts_t sts;

	assign cfg_ready = 1'b1;

	rois_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.mode      (mode),
		.out_stall (out_stall),
		.sts       (sts),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	rois_dp #(
		.MAX_W (MAX_W),
		.MAX_H (MAX_H),
		.OUT_W (OUT_W),
		.OUT_H (OUT_H)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.col       (col),
		.row       (row),
		.pixel_in  (pixel_in),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel_out (pixel_out),
		.out_col   (out_col),
		.out_row   (out_row)
	);

endmodule

`default_nettype wire
